### hw/rtl/startup_word_scramble_diff_encode_core_macros.svh
// Assertion macros shared by the checker files of the startup word encoder
`ifndef STARTUP_WORD_SCRAMBLE_DIFF_ENCODE_CORE_MACROS_SVH
`define STARTUP_WORD_SCRAMBLE_DIFF_ENCODE_CORE_MACROS_SVH

// Clocked check, switched off while reset is held
`define SWDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check, active on every edge
`define SWDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/swde_pkg.sv
// Shared types, constants and the differential table of the startup word encoder
package swde_pkg;

    localparam int WORD_W = 16;
    localparam int SCR_W  = 23;
    localparam int DIFF_W = 2;
    localparam int N_SYM  = WORD_W / 2;

    // scrambler taps
    localparam int TAP_HIGH      = 22;
    localparam int TAP_CALLING   = 17;
    localparam int TAP_ANSWERING = 4;

    // request modes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    typedef logic [DIFF_W-1:0] t_diff;
    typedef logic [SCR_W-1:0]  t_scr;
    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  mode;
        t_word word;
        t_scr  seed_scrambler;
        t_diff seed_diff;
    } t_request;

    typedef struct packed {
        t_word symbols;
        t_scr  scrambler_now;
        t_diff diff_now;
    } t_result;

    // next differential state, indexed by [previous state][dibit]
    localparam t_diff DIFF_TABLE [0:3][0:3] = '{
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd2, 2'd0},
        '{2'd1, 2'd0, 2'd3, 2'd2}
    };

    function automatic t_diff diff_next(input t_diff st, input t_diff dibit);
        return DIFF_TABLE[st][dibit];
    endfunction

    // one scrambled bit: input XOR bit 22 XOR side tap
    function automatic logic scr_bit(input t_scr reg_v, input logic calling,
                                     input logic data);
        logic side;
        side = calling ? reg_v[TAP_CALLING] : reg_v[TAP_ANSWERING];
        return data ^ reg_v[TAP_HIGH] ^ side;
    endfunction

endpackage

### hw/rtl/swde_in_if.sv
// Request channel: encode or load request with valid/ready
interface swde_in_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    swde_pkg::t_word      word;
    swde_pkg::t_scr       seed_scrambler;
    swde_pkg::t_diff      seed_diff;

    modport source (output valid, mode, word, seed_scrambler, seed_diff, input ready);
    modport sink   (input valid, mode, word, seed_scrambler, seed_diff, output ready);
endinterface

### hw/rtl/swde_out_if.sv
// Result channel: symbols and updated state with valid/ready
interface swde_out_if;
    logic                 valid;
    logic                 ready;
    swde_pkg::t_word      symbols;
    swde_pkg::t_scr       scrambler_now;
    swde_pkg::t_diff      diff_now;

    modport source (output valid, symbols, scrambler_now, diff_now, input ready);
    modport sink   (input valid, symbols, scrambler_now, diff_now, output ready);
endinterface

### hw/rtl/swde_cfg_if.sv
// Configuration write channel: calling side select
interface swde_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/startup_word_scramble_diff_encode_core.sv
// Top level of the startup word scrambler and differential encoder
//
// Channels: i_in takes requests (mode, word, seeds), o_out gives one result per
// request (symbols, scrambler_now, diff_now), i_cfg writes the calling side
// select. i_cfg is always ready; write it only while no request is in flight.
// A request is held in an input register, encoded by one pass of combinational
// logic (sixteen scrambler steps, eight table lookups) and captured in the
// result register, where the scrambler and differential state update as well.
// A taken request passes through the input register and then the result register
// before o_out.valid rises. Throughput: one request per cycle while the receiver
// does not stall; each request uses the scrambler and differential state left by
// the request before it.
// Reset (i_rst_n low at a clock edge) clears both registers' valid flags, the
// scrambler, the differential state and the calling side select.
// When the receiver stalls, the result holds and the input register keeps one
// more request; i_in.ready then drops until the result is taken.
module startup_word_scramble_diff_encode_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swde_in_if.sink    i_in,
    swde_out_if.source o_out,
    swde_cfg_if.sink   i_cfg
);

    logic               r_in_valid;
    logic               n_in_valid;
    swde_pkg::t_request r_in;
    logic               r_out_valid;
    logic               n_out_valid;
    swde_pkg::t_result  r_out;
    swde_pkg::t_result  n_out;
    swde_pkg::t_scr     r_scr;
    swde_pkg::t_diff    r_diff;
    logic               r_calling_side;
    logic               in_acc;
    logic               adv;

    // handshake
    assign adv         = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || adv;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign n_in_valid  = in_acc || (r_in_valid && !adv);
    assign n_out_valid = adv || (r_out_valid && !o_out.ready);

    swde_encoder u_enc (
        .i_calling_side (r_calling_side),
        .i_req          (r_in),
        .i_scr          (r_scr),
        .i_diff         (r_diff),
        .o_res          (n_out)
    );

    // control and kept state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_scr          <= '0;
            r_diff         <= '0;
            r_calling_side <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (adv) begin
                r_scr  <= n_out.scrambler_now;
                r_diff <= n_out.diff_now;
            end
            if (i_cfg.valid) begin
                r_calling_side <= i_cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.mode           <= i_in.mode;
            r_in.word           <= i_in.word;
            r_in.seed_scrambler <= i_in.seed_scrambler;
            r_in.seed_diff      <= i_in.seed_diff;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // result port
    assign o_out.valid         = r_out_valid;
    assign o_out.symbols       = r_out.symbols;
    assign o_out.scrambler_now = r_out.scrambler_now;
    assign o_out.diff_now      = r_out.diff_now;

endmodule

### hw/rtl/swde_encoder.sv
// Combinational scrambler and differential encoder for one request
module swde_encoder (
    input  logic               i_calling_side,
    input  swde_pkg::t_request i_req,
    input  swde_pkg::t_scr     i_scr,
    input  swde_pkg::t_diff    i_diff,
    output swde_pkg::t_result  o_res
);

    swde_pkg::t_scr  scr;
    swde_pkg::t_diff st;
    swde_pkg::t_word sym;
    logic            b0;
    logic            b1;

    // eight symbols, two scrambler steps each, low bit pair first
    always_comb begin
        scr = i_scr;
        st  = i_diff;
        sym = '0;
        b0  = 1'b0;
        b1  = 1'b0;
        for (int i = 0; i < swde_pkg::N_SYM; i++) begin
            b0  = swde_pkg::scr_bit(scr, i_calling_side, i_req.word[2*i]);
            scr = {scr[swde_pkg::SCR_W-2:0], b0};
            b1  = swde_pkg::scr_bit(scr, i_calling_side, i_req.word[2*i+1]);
            scr = {scr[swde_pkg::SCR_W-2:0], b1};
            st  = swde_pkg::diff_next(st, {b1, b0});
            sym[2*i +: swde_pkg::DIFF_W] = st;
        end
    end

    // load requests seed the state and report zero symbols
    always_comb begin
        if (i_req.mode == swde_pkg::MODE_LOAD) begin
            o_res.symbols       = '0;
            o_res.scrambler_now = i_req.seed_scrambler;
            o_res.diff_now      = i_req.seed_diff;
        end else begin
            o_res.symbols       = sym;
            o_res.scrambler_now = scr;
            o_res.diff_now      = st;
        end
    end

endmodule

### hw/rtl/swde_checker.sv
// Port-level checks for the startup word encoder, bound to the top level
`include "startup_word_scramble_diff_encode_core_macros.svh"

module swde_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // every accepted request is followed by a valid result on the output port
    `SWDE_ASSERT(a_latency, i_clk, i_rst_n, in_acc |-> ##2 i_out_valid, "result missing after request")

    // a request still held behind a stalled result blocks further requests
    `SWDE_ASSERT(a_backpressure, i_clk, i_rst_n, ($past(in_acc) && i_out_valid && !i_out_ready) |-> !i_in_ready, "request taken while full")

    // first cycle after reset: nothing pending, input open
    `SWDE_ASSERT(a_reset_clear, i_clk, i_rst_n, $past(!i_rst_n) |-> (!i_out_valid && i_in_ready), "state not cleared by reset")

    // a result only leaves once it has been taken
    `SWDE_ASSERT(a_no_drop, i_clk, i_rst_n, ($fell(i_out_valid) && $past(i_rst_n)) |-> $past(i_out_ready), "result dropped")

endmodule

bind startup_word_scramble_diff_encode_core swde_checker u_swde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

### tb/swde_encode_checker.sv
// Checker for the startup word encoder: predicts each result and compares it
`timescale 1ns / 1ps

module swde_encode_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    swde_in_if   in_ch,
    swde_out_if  out_ch,
    swde_cfg_if  cfg_ch,
    output int   o_mismatch_count,
    output int   o_outstanding
);

    // next line state, indexed by [previous state][dibit]
    localparam logic [1:0] NEXT_LINE_STATE [4][4] = '{
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd2, 2'd0},
        '{2'd1, 2'd0, 2'd3, 2'd2}
    };

    swde_pkg::t_scr    model_scr;
    swde_pkg::t_diff   model_diff;
    logic              model_calling;
    swde_pkg::t_result expected_results[$];
    int                mismatch_count;

    // Scramble an encode word bit by bit, mapping each dibit to the next line state;
    // a load takes the seeds. The returned scrambler_now and diff_now double as the new kept state.
    function automatic swde_pkg::t_result encode_request(input swde_pkg::t_request req,
                                                         input swde_pkg::t_scr scr,
                                                         input swde_pkg::t_diff diff,
                                                         input logic calling);
        swde_pkg::t_result res;
        swde_pkg::t_scr    sr;
        swde_pkg::t_diff   st;
        swde_pkg::t_diff   dibit;
        logic              fb;
        res = '0;
        if (req.mode == swde_pkg::MODE_LOAD) begin
            res.scrambler_now = req.seed_scrambler;
            res.diff_now      = req.seed_diff;
        end else begin
            sr    = scr;
            st    = diff;
            dibit = '0;
            for (int b = 0; b < swde_pkg::WORD_W; b++) begin
                fb = req.word[b] ^ sr[swde_pkg::TAP_HIGH]
                     ^ (calling ? sr[swde_pkg::TAP_CALLING] : sr[swde_pkg::TAP_ANSWERING]);
                sr = {sr[swde_pkg::SCR_W-2:0], fb};
                dibit[b % 2] = fb;
                if (b % 2 == 1) begin
                    st = NEXT_LINE_STATE[st][dibit];
                    res.symbols[b-1 +: 2] = st;
                end
            end
            res.scrambler_now = sr;
            res.diff_now      = st;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        swde_pkg::t_request req;
        swde_pkg::t_result  exp_res;
        swde_pkg::t_result  got;
        if (!i_rst_n) begin
            model_scr     = '0;
            model_diff    = '0;
            model_calling = 1'b0;
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            // result side: compare with the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                got.symbols       = out_ch.symbols;
                got.scrambler_now = out_ch.scrambler_now;
                got.diff_now      = out_ch.diff_now;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: symbols %h", got.symbols);
                    mismatch_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.symbols !== exp_res.symbols) begin
                        $error("symbols: expected %h, actual %h",
                               exp_res.symbols, got.symbols);
                        mismatch_count++;
                    end
                    if (got.scrambler_now !== exp_res.scrambler_now) begin
                        $error("scrambler_now: expected %h, actual %h",
                               exp_res.scrambler_now, got.scrambler_now);
                        mismatch_count++;
                    end
                    if (got.diff_now !== exp_res.diff_now) begin
                        $error("diff_now: expected %h, actual %h",
                               exp_res.diff_now, got.diff_now);
                        mismatch_count++;
                    end
                end
            end
            // side select write
            if (cfg_ch.valid && cfg_ch.ready)
                model_calling = cfg_ch.data;
            // request side: predict and update the kept state
            if (in_ch.valid && in_ch.ready) begin
                req.mode           = in_ch.mode;
                req.word           = in_ch.word;
                req.seed_scrambler = in_ch.seed_scrambler;
                req.seed_diff      = in_ch.seed_diff;
                exp_res    = encode_request(req, model_scr, model_diff, model_calling);
                model_scr  = exp_res.scrambler_now;
                model_diff = exp_res.diff_now;
                expected_results.push_back(exp_res);
            end
        end
        o_mismatch_count <= mismatch_count;
        o_outstanding    <= expected_results.size();
    end

endmodule

### tb/tb.sv
// Testbench top for the startup word encoder: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 106;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   outstanding;
    int   in_idle_pct;
    int   out_idle_pct;

    swde_in_if  in_ch ();
    swde_out_if out_ch ();
    swde_cfg_if cfg_ch ();

    startup_word_scramble_diff_encode_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    swde_encode_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .in_ch            (in_ch),
        .out_ch           (out_ch),
        .cfg_ch           (cfg_ch),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver stalls at random
    always @(negedge clk) begin
        out_ch.ready = ($urandom_range(99) >= out_idle_pct);
    end

    // Drive one request from a falling edge; returns at the falling edge after
    // acceptance with valid still high.
    task automatic send_request(input logic mode, input swde_pkg::t_word word,
                                input swde_pkg::t_scr seed_s,
                                input swde_pkg::t_diff seed_d);
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid          = 1'b1;
        in_ch.mode           = mode;
        in_ch.word           = word;
        in_ch.seed_scrambler = seed_s;
        in_ch.seed_diff      = seed_d;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // hold off requests until every result has come back
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_side(input logic calling);
        wait_drained();
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = calling;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic swde_pkg::t_word pick_word();
        unique case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return ($urandom_range(1) != 0) ? 16'hAAAA : 16'h5555;
            default: return swde_pkg::t_word'($urandom);
        endcase
    endfunction

    function automatic swde_pkg::t_scr pick_seed();
        unique case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return swde_pkg::t_scr'($urandom);
        endcase
    endfunction

    // watchdog: give up after a long stretch with no handshake at all
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic calling;
        in_idle_pct          = 10;
        out_idle_pct         = 10;
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.mode           = swde_pkg::MODE_ENCODE;
        in_ch.word           = '0;
        in_ch.seed_scrambler = '0;
        in_ch.seed_diff      = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // answering side from reset: zero state, extremes, ignored fields, taps
        send_request(swde_pkg::MODE_ENCODE, 16'h0000, '0, '0);
        send_request(swde_pkg::MODE_ENCODE, 16'hFFFF, '0, '0);
        send_request(swde_pkg::MODE_LOAD,   16'hFFFF, 23'h7FFFFF, 2'd3);
        send_request(swde_pkg::MODE_ENCODE, 16'h0000, '0, '0);
        send_request(swde_pkg::MODE_ENCODE, 16'hAAAA, 23'h7FFFFF, 2'd3);
        send_request(swde_pkg::MODE_ENCODE, 16'h5555, '0, '0);
        send_request(swde_pkg::MODE_LOAD,   16'h1234, '0, 2'd0);
        send_request(swde_pkg::MODE_ENCODE, 16'h0001, '0, '0);
        send_request(swde_pkg::MODE_LOAD,   16'h0000, 23'h000010, 2'd1);
        send_request(swde_pkg::MODE_ENCODE, 16'h8000, '0, '0);
        send_request(swde_pkg::MODE_LOAD,   16'h0000, 23'h400000, 2'd2);
        send_request(swde_pkg::MODE_ENCODE, 16'h0000, '0, '0);
        send_request(swde_pkg::MODE_LOAD,   16'h0000, 23'h020000, 2'd3);
        send_request(swde_pkg::MODE_ENCODE, 16'h0000, '0, '0);

        // calling side
        write_side(1'b1);
        send_request(swde_pkg::MODE_ENCODE, 16'h0000, '0, '0);
        send_request(swde_pkg::MODE_LOAD,   16'hFFFF, 23'h020000, 2'd0);
        send_request(swde_pkg::MODE_ENCODE, 16'h0000, '0, '0);
        send_request(swde_pkg::MODE_LOAD,   16'h0000, 23'h000010, 2'd1);
        send_request(swde_pkg::MODE_ENCODE, 16'hFFFF, '0, '0);
        send_request(swde_pkg::MODE_LOAD,   16'h0000, 23'h7FFFFF, 2'd2);
        send_request(swde_pkg::MODE_ENCODE, 16'h5A5A, 23'h7FFFFF, 2'd3);
        send_request(swde_pkg::MODE_ENCODE, 16'hFFFF, '0, '0);

        // random phases, each starting from a drained block with the side written anew
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase < 2)
                calling = phase[0];
            else
                calling = 1'($urandom_range(1));
            write_side(calling);
            // one phase runs flat out on both sides
            in_idle_pct  = (phase == 2) ? 0 : 10;
            out_idle_pct = (phase == 2) ? 0 : 10;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(7) == 0)
                    send_request(swde_pkg::MODE_LOAD, swde_pkg::t_word'($urandom),
                                 pick_seed(), swde_pkg::t_diff'($urandom_range(3)));
                else
                    send_request(swde_pkg::MODE_ENCODE, pick_word(),
                                 swde_pkg::t_scr'($urandom),
                                 swde_pkg::t_diff'($urandom_range(3)));
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
